// File: rtl/ssac_pkg.sv
// Shared types and constants for the servo and stepper axis controller.
`default_nettype none
package ssac_pkg;

  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 56;
  localparam int KIND_W      = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [1:0] {
    KIND_STEP_TICK  = 2'd0,
    KIND_SERVO_TICK = 2'd1,
    KIND_MOVE       = 2'd2,
    KIND_JOG        = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    CFG_COMPARE_MIN      = 3'd0,
    CFG_COMPARE_MAX      = 3'd1,
    CFG_SERVO_GAIN       = 3'd2,
    CFG_SETTLE_BASE      = 3'd3,
    CFG_SETTLE_PER_COUNT = 3'd4,
    CFG_STEP_GAIN        = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MUL_COMPARE = 2'd0,
    MUL_SETTLE  = 2'd1,
    MUL_STEP    = 2'd2
  } mul_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL_CMP,
    S_CLAMP,
    S_MUL_SETTLE,
    S_MUL_STEP,
    S_COMMIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic     capture;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     clamp_en;
    logic     settle_en;
    logic     commit_en;
    logic     tick_en;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  axes_idle;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/ssac_ctrl.sv
// Sequencer for event handling, the move arithmetic steps and the output register.
`default_nettype none
module ssac_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire ssac_pkg::dp_stat_t stat,
  output ssac_pkg::dp_cmd_t      cmd
);
  import ssac_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_sel = MUL_COMPARE;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.kind == KIND_MOVE && stat.axes_idle) begin
          state_next = S_MUL_CMP;
        end else begin
          cmd.tick_en = 1'b1;
          state_next  = S_EMIT;
        end
      end
      S_MUL_CMP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_COMPARE;
        state_next  = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.clamp_en = 1'b1;
        state_next   = S_MUL_SETTLE;
      end
      S_MUL_SETTLE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SETTLE;
        state_next  = S_MUL_STEP;
      end
      S_MUL_STEP: begin
        // settle sum takes the previous product while the multiplier moves on
        cmd.settle_en = 1'b1;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MUL_STEP;
        state_next    = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit_en = 1'b1;
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ssac_dp.sv
// Datapath: configuration, axis state, shared multiplier and result register.
`default_nettype none
module ssac_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [ssac_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [ssac_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic [ssac_pkg::IN_DATA_W-1:0]       in_data,
  input  wire logic [ssac_pkg::KIND_W-1:0]          in_kind,
  input  wire ssac_pkg::dp_cmd_t                    cmd,
  output ssac_pkg::dp_stat_t                        stat,
  output logic [ssac_pkg::OUT_DATA_W-1:0]           out_data
);
  import ssac_pkg::*;

  // configuration
  logic [15:0] cmin, cmax, sper;
  logic [23:0] sgain;
  logic [31:0] sbase, stgain;

  // captured item
  kind_t       kind_q;
  logic [15:0] x_q;
  logic [23:0] y_q;
  logic [1:0]  jog_dir_q;
  logic        held_q;

  // axis state
  logic [15:0] compare_value, compare_value_next;
  logic [31:0] settle_count, settle_count_next;
  logic        servo_wait, servo_wait_next;
  logic [31:0] position_steps, position_steps_next;
  logic [31:0] goal_steps, goal_steps_next;
  logic        dir_level, dir_level_next;
  logic        pulse_level, pulse_level_next;
  logic [1:0]  jog_mode, jog_mode_next;
  logic        stepper_run, stepper_run_next;

  // move arithmetic
  logic [23:0] mul_a;
  logic [31:0] mul_b;
  logic [55:0] prod_q;
  logic [24:0] c_sum;
  logic [15:0] nc, nc_q, diff, diff_q;
  logic [32:0] wait_sum;
  logic [31:0] settle_q;
  logic        y_neg;
  logic [23:0] y_mag;
  logic [39:0] q_steps;
  logic [31:0] q_sat, target_calc;
  logic        at_target, want_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmin   <= 16'd0;
      cmax   <= 16'hFFFF;
      sgain  <= 24'd65536;
      sbase  <= 32'd0;
      sper   <= 16'd0;
      stgain <= 32'd65536;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_COMPARE_MIN:      cmin   <= cfg_data[15:0];
        CFG_COMPARE_MAX:      cmax   <= cfg_data[15:0];
        CFG_SERVO_GAIN:       sgain  <= cfg_data[23:0];
        CFG_SETTLE_BASE:      sbase  <= cfg_data;
        CFG_SETTLE_PER_COUNT: sper   <= cfg_data[15:0];
        CFG_STEP_GAIN:        stgain <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q    <= kind_t'(in_kind);
      x_q       <= in_data[15:0];
      y_q       <= in_data[39:16];
      jog_dir_q <= in_data[41:40];
      held_q    <= in_data[42];
    end
  end

  assign y_neg = y_q[23];
  assign y_mag = y_neg ? (~y_q + 24'd1) : y_q;

  always_comb begin
    case (cmd.mul_sel)
      MUL_COMPARE: begin
        mul_a = sgain;
        mul_b = {16'd0, x_q};
      end
      MUL_SETTLE: begin
        mul_a = {8'd0, diff_q};
        mul_b = {16'd0, sper};
      end
      MUL_STEP: begin
        mul_a = y_mag;
        mul_b = stgain;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
  end

  // compare = gain*x >> 16 plus minimum, capped at maximum
  assign c_sum = {1'b0, prod_q[39:16]} + {9'd0, cmin};
  assign nc    = (c_sum > {9'd0, cmax}) ? cmax : c_sum[15:0];
  assign diff  = (nc >= compare_value) ? (nc - compare_value) : (compare_value - nc);

  assign wait_sum = {1'b0, sbase} + {1'b0, prod_q[31:0]};

  // scaled y target, truncated toward zero, saturated to signed 32 bits
  assign q_steps = prod_q[55:16];
  always_comb begin
    if (y_neg) begin
      q_sat       = (q_steps > 40'h0080000000) ? 32'h80000000 : q_steps[31:0];
      target_calc = 32'd0 - q_sat;
    end else begin
      q_sat       = (q_steps > 40'h007FFFFFFF) ? 32'h7FFFFFFF : q_steps[31:0];
      target_calc = q_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clamp_en) begin
      nc_q   <= nc;
      diff_q <= diff;
    end
    if (cmd.settle_en) begin
      settle_q <= wait_sum[32] ? 32'hFFFFFFFF : wait_sum[31:0];
    end
  end

  // wanted direction of the stepper for this tick
  always_comb begin
    if (jog_mode != 2'd0) begin
      at_target = 1'b0;
      want_up   = (jog_mode == 2'b01);
    end else begin
      at_target = (goal_steps == position_steps);
      want_up   = $signed(goal_steps) > $signed(position_steps);
    end
  end

  always_comb begin
    compare_value_next  = compare_value;
    settle_count_next   = settle_count;
    servo_wait_next     = servo_wait;
    position_steps_next = position_steps;
    goal_steps_next     = goal_steps;
    dir_level_next      = dir_level;
    pulse_level_next    = pulse_level;
    jog_mode_next       = jog_mode;
    stepper_run_next    = stepper_run;
    if (cmd.commit_en) begin
      compare_value_next = nc_q;
      settle_count_next  = settle_q;
      servo_wait_next    = 1'b1;
      goal_steps_next    = target_calc;
      stepper_run_next   = 1'b1;
    end else if (cmd.tick_en) begin
      case (kind_q)
        KIND_STEP_TICK: begin
          if (stepper_run) begin
            if (jog_mode != 2'd0 && !held_q) begin
              stepper_run_next = 1'b0;
              jog_mode_next    = 2'd0;
            end else if (at_target) begin
              stepper_run_next = 1'b0;
            end else if (want_up != dir_level) begin
              // change direction first, pulse on later ticks
              dir_level_next = want_up;
            end else begin
              pulse_level_next = ~pulse_level;
              if (!pulse_level && jog_mode == 2'd0) begin
                position_steps_next = dir_level ? (position_steps + 32'd1)
                                                : (position_steps - 32'd1);
              end
            end
          end
        end
        KIND_SERVO_TICK: begin
          if (servo_wait) begin
            if (settle_count == 32'd0) begin
              servo_wait_next = 1'b0;
            end else begin
              settle_count_next = settle_count - 32'd1;
            end
          end
        end
        KIND_JOG: begin
          jog_mode_next    = jog_dir_q;
          stepper_run_next = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      compare_value  <= 16'd0;
      settle_count   <= 32'd0;
      servo_wait     <= 1'b0;
      position_steps <= 32'd0;
      goal_steps     <= 32'd0;
      dir_level      <= 1'b1;
      pulse_level    <= 1'b1;
      jog_mode       <= 2'd0;
      stepper_run    <= 1'b0;
    end else begin
      compare_value  <= compare_value_next;
      settle_count   <= settle_count_next;
      servo_wait     <= servo_wait_next;
      position_steps <= position_steps_next;
      goal_steps     <= goal_steps_next;
      dir_level      <= dir_level_next;
      pulse_level    <= pulse_level_next;
      jog_mode       <= jog_mode_next;
      stepper_run    <= stepper_run_next;
    end
  end

  assign stat.kind      = kind_q;
  assign stat.axes_idle = !servo_wait && !stepper_run;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {3'd0, !servo_wait && !stepper_run, stepper_run, servo_wait,
                   position_steps, compare_value, dir_level, pulse_level};
    end
  end

endmodule
`default_nettype wire

// File: rtl/servo_stepper_axis_controller_core.sv
// Top level of the two-axis servo and stepper controller.
// A tick or jog transaction is taken in IDLE and then passes EXEC and EMIT; a move
// taken with both axes idle also passes MUL_CMP, CLAMP, MUL_SETTLE, MUL_STEP and
// COMMIT before EMIT (three passes through one shared multiplier). The
// sequencer handles one item at a time, the output register frees the input side.
// Reset: synchronous, clears the axis state and loads the configuration defaults.
`default_nettype none
module servo_stepper_axis_controller_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // x_pos[15:0], y_pos[39:16], jog_dir[41:40], jog_held[42], zero fill
  input  wire logic [ssac_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // kind[1:0]
  input  wire logic [ssac_pkg::KIND_W-1:0]         s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // step_pulse[0], step_dir[1], servo_compare[17:2], step_position[49:18],
  // servo_busy[50], stepper_busy[51], ready_res[52], zero fill
  output logic [ssac_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
  input  wire logic                                cfg_wr_en,
  input  wire logic [ssac_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [ssac_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ssac_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ssac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ssac_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .in_kind   (s_axis_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (m_axis_tdata)
  );

endmodule
`default_nettype wire
